@@ src/glc_pkg.sv @@
`default_nettype none
package glc_pkg;

  localparam int MaxClusters = 16;
  localparam int IdxW        = $clog2(MaxClusters);
  localparam int CntW        = $clog2(MaxClusters + 1);
  localparam int CoordW      = 11;
  localparam int VoteW       = 16;
  localparam int TotalW      = 32;
  localparam int DistW       = 11;
  localparam int Lim2W       = 2 * DistW;
  localparam int DiffW       = CoordW + 1;
  localparam int D2W         = 2 * DiffW;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 11;
  localparam int ClimW       = 5;

  localparam logic [DistW-1:0]  DistLimitRst   = 11'd5;
  localparam logic [ClimW-1:0]  ClusterLimitRst = 5'd16;
  localparam logic [TotalW-1:0] TotalMax       = {TotalW{1'b1}};

  localparam logic [CfgIdxW-1:0] CfgIdxDistance = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxClusters = 1'b1;

  localparam logic CmdCluster = 1'b0;
  localparam logic CmdClear   = 1'b1;

  typedef enum logic [1:0] {
    ST_JOINED  = 2'd0,
    ST_NEW     = 2'd1,
    ST_IGNORED = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [TotalW-1:0]        total;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          data;
  } tbl_wr_t;

  typedef struct packed {
    logic            vld;
    logic [IdxW-1:0] idx;
    entry_t          ent;
    logic [D2W-1:0]  d2;
  } dist_res_t;

endpackage
`default_nettype wire

@@ src/glc_table.sv @@
`default_nettype none
module glc_table (
  input  wire logic                      clk,
  input  wire glc_pkg::tbl_wr_t          wr,
  input  wire logic [glc_pkg::IdxW-1:0]  rd_addr,
  output glc_pkg::entry_t                rd_data
);

  glc_pkg::entry_t mem_r [glc_pkg::MaxClusters];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = mem_r[rd_addr];

endmodule
`default_nettype wire

@@ src/glc_dist_unit.sv @@
`default_nettype none
module glc_dist_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              issue,
  input  wire logic [glc_pkg::IdxW-1:0]          idx,
  input  wire glc_pkg::entry_t                   ent,
  input  wire logic signed [glc_pkg::CoordW-1:0] px,
  input  wire logic signed [glc_pkg::CoordW-1:0] py,
  output glc_pkg::dist_res_t                     res
);

  logic signed [glc_pkg::DiffW-1:0] dx;
  logic signed [glc_pkg::DiffW-1:0] dy;
  logic signed [glc_pkg::D2W-1:0]   sqx;
  logic signed [glc_pkg::D2W-1:0]   sqy;
  logic [glc_pkg::D2W-1:0]          d2;
  logic                             vld_r;
  logic [glc_pkg::IdxW-1:0]         idx_r;
  glc_pkg::entry_t                  ent_r;
  logic [glc_pkg::D2W-1:0]          d2_r;

  assign dx  = glc_pkg::DiffW'(px) - glc_pkg::DiffW'(ent.x);
  assign dy  = glc_pkg::DiffW'(py) - glc_pkg::DiffW'(ent.y);
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  // each square is below 2^22, so the sum fits unsigned
  assign d2  = glc_pkg::D2W'($unsigned(sqx)) + glc_pkg::D2W'($unsigned(sqy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx;
    ent_r <= ent;
    d2_r  <= d2;
  end

  assign res = {vld_r, idx_r, ent_r, d2_r};

endmodule
`default_nettype wire

@@ src/greedy_leader_point_clustering_unit.sv @@
// A point is compared with the stored clusters in index order in the scan state, then the
// update state writes the table and registers the result; a join ends the scan at the
// matching index, and clear and ignored items go straight to the update. The update waits
// while an unaccepted result is held. Throughput: one item at a time, one stored centre per
// cycle through the shared distance unit; the next item is taken once the result is registered.
// Reset (rst_n, synchronous, active low) zeroes the cluster count, limits back to 5 and 16.
`default_nettype none
module greedy_leader_point_clustering_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [39:0]                   in_tdata,  // point_x, point_y, vote_count, pad
  input  wire logic                          in_tuser,  // cmd
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [63:0]                        out_tdata, // cluster_index, center_x, center_y,
                                                        // cluster_total, pad
  output logic [1:0]                         out_tuser, // status
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [glc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [glc_pkg::CfgDataW-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t                            state_r, state_nxt;
  logic [glc_pkg::CntW-1:0]          found_r, found_nxt;
  logic [glc_pkg::CntW-1:0]          scan_r, scan_nxt;
  logic signed [glc_pkg::CoordW-1:0] px_r, py_r;
  logic [glc_pkg::VoteW-1:0]         votes_r;
  logic [glc_pkg::Lim2W-1:0]         lim2_r;
  glc_pkg::status_t                  kind_r, kind_nxt;
  logic [glc_pkg::IdxW-1:0]          hit_idx_r;
  glc_pkg::entry_t                   hit_ent_r;
  logic [glc_pkg::DistW-1:0]         dist_lim_r;
  logic [glc_pkg::ClimW-1:0]         clu_lim_r;
  logic                              out_valid_r, out_valid_nxt;
  glc_pkg::status_t                  out_status_r;
  logic [glc_pkg::IdxW-1:0]          out_idx_r;
  glc_pkg::entry_t                   out_ent_r;

  logic                              in_acc;
  logic                              out_free;
  logic [glc_pkg::CntW-1:0]          elim;
  logic                              issue;
  logic                              hit;
  logic [glc_pkg::TotalW:0]          sum;
  logic [glc_pkg::TotalW-1:0]        sat_total;
  logic                              upd_go;
  glc_pkg::tbl_wr_t                  wr;
  glc_pkg::entry_t                   rd_ent;
  glc_pkg::dist_res_t                dres;
  logic signed [glc_pkg::CoordW-1:0] in_px, in_py;
  logic [glc_pkg::VoteW-1:0]         in_votes;

  assign in_px    = in_tdata[10:0];
  assign in_py    = in_tdata[21:11];
  assign in_votes = in_tdata[37:22];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  // a limit of zero acts as one, above the table size as the table size
  always_comb begin
    if (clu_lim_r == '0) begin
      elim = glc_pkg::CntW'(1);
    end else if (glc_pkg::CntW'(clu_lim_r) > glc_pkg::CntW'(glc_pkg::MaxClusters)) begin
      elim = glc_pkg::CntW'(glc_pkg::MaxClusters);
    end else begin
      elim = glc_pkg::CntW'(clu_lim_r);
    end
  end

  assign hit   = (state_r == S_SCAN) && dres.vld &&
                 (dres.d2 < glc_pkg::D2W'(lim2_r));
  assign issue = (state_r == S_SCAN) && !hit && (scan_r < found_r);
  assign upd_go = (state_r == S_UPD) && out_free;

  assign sum       = (glc_pkg::TotalW+1)'(hit_ent_r.total) + (glc_pkg::TotalW+1)'(votes_r);
  assign sat_total = sum[glc_pkg::TotalW] ? glc_pkg::TotalMax : sum[glc_pkg::TotalW-1:0];

  glc_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (scan_r[glc_pkg::IdxW-1:0]),
    .rd_data (rd_ent)
  );

  glc_dist_unit u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .issue (issue),
    .idx   (scan_r[glc_pkg::IdxW-1:0]),
    .ent   (rd_ent),
    .px    (px_r),
    .py    (py_r),
    .res   (dres)
  );

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    scan_nxt      = scan_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    wr            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          scan_nxt = '0;
          if (in_tuser == glc_pkg::CmdClear) begin
            kind_nxt  = glc_pkg::ST_CLEARED;
            state_nxt = S_UPD;
          end else if (found_r >= elim) begin
            kind_nxt  = glc_pkg::ST_IGNORED;
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          kind_nxt  = glc_pkg::ST_JOINED;
          state_nxt = S_UPD;
        end else if (issue) begin
          scan_nxt = scan_r + glc_pkg::CntW'(1);
        end else begin
          kind_nxt  = glc_pkg::ST_NEW;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (kind_r)
            glc_pkg::ST_CLEARED: found_nxt = '0;
            glc_pkg::ST_JOINED: begin
              wr.en         = 1'b1;
              wr.addr       = hit_idx_r;
              wr.data       = hit_ent_r;
              wr.data.total = sat_total;
            end
            glc_pkg::ST_NEW: begin
              wr.en         = 1'b1;
              wr.addr       = found_r[glc_pkg::IdxW-1:0];
              wr.data.x     = px_r;
              wr.data.y     = py_r;
              wr.data.total = glc_pkg::TotalW'(votes_r);
              found_nxt     = found_r + glc_pkg::CntW'(1);
            end
            default: ;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      found_r     <= '0;
      scan_r      <= '0;
      kind_r      <= glc_pkg::ST_IGNORED;
      out_valid_r <= 1'b0;
      dist_lim_r  <= glc_pkg::DistLimitRst;
      clu_lim_r   <= glc_pkg::ClusterLimitRst;
    end else begin
      state_r     <= state_nxt;
      found_r     <= found_nxt;
      scan_r      <= scan_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == glc_pkg::CfgIdxDistance) begin
          dist_lim_r <= cfg_data[glc_pkg::DistW-1:0];
        end else begin
          clu_lim_r <= cfg_data[glc_pkg::ClimW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r    <= in_px;
      py_r    <= in_py;
      votes_r <= in_votes;
      lim2_r  <= glc_pkg::Lim2W'(dist_lim_r) * glc_pkg::Lim2W'(dist_lim_r);
    end
    if (hit) begin
      hit_idx_r <= dres.idx;
      hit_ent_r <= dres.ent;
    end
    if (upd_go) begin
      out_status_r <= kind_r;
      unique case (kind_r)
        glc_pkg::ST_JOINED: begin
          out_idx_r       <= hit_idx_r;
          out_ent_r.x     <= hit_ent_r.x;
          out_ent_r.y     <= hit_ent_r.y;
          out_ent_r.total <= sat_total;
        end
        glc_pkg::ST_NEW: begin
          out_idx_r       <= found_r[glc_pkg::IdxW-1:0];
          out_ent_r.x     <= px_r;
          out_ent_r.y     <= py_r;
          out_ent_r.total <= glc_pkg::TotalW'(votes_r);
        end
        default: begin
          out_idx_r <= '0;
          out_ent_r <= '0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {6'b0, out_ent_r.total, out_ent_r.y, out_ent_r.x, out_idx_r};

endmodule
`default_nettype wire
